/* rtl/core/aarm_pkg.sv */
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared widths, constants, CORDIC arctangent table and the cell word type
// for the axis-angle rotation matrix core.
// ----------------------------------------------------------------------------
package aarm_pkg;

    localparam int ANGLE_W            = 16;
    localparam int AXIS_W             = 16;
    localparam int ENTRY_W            = 17;
    localparam int N_ENTRIES          = 9;
    localparam int S_TDATA_W          = 64;
    localparam int M_TDATA_W          = 160;

    localparam int FRAC_BITS_DEF      = 14;
    localparam int CORDIC_STAGES_DEF  = 16;
    localparam int ATAN_TAB_LEN       = 24;

    // CORDIC datapath: Q30 vectors, angle in units where 2^31 = pi
    localparam int INT_FRAC           = 30;
    localparam int XY_W               = 34;
    localparam int Z_W                = 33;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(64'sd652032874);
    localparam logic signed [Z_W-1:0]  HALF_TURN   = Z_W'(64'sd2147483648);

    typedef struct packed {
        logic signed [XY_W-1:0]   x;
        logic signed [XY_W-1:0]   y;
        logic signed [Z_W-1:0]    z;
        logic signed [AXIS_W-1:0] ux;
        logic signed [AXIS_W-1:0] uy;
        logic signed [AXIS_W-1:0] uz;
        logic                     flip;
    } cordic_t;

    function automatic logic signed [Z_W-1:0] atan_q31(input int unsigned idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            0:       val = Z_W'(64'sd536870912);
            1:       val = Z_W'(64'sd316933406);
            2:       val = Z_W'(64'sd167458907);
            3:       val = Z_W'(64'sd85004756);
            4:       val = Z_W'(64'sd42667331);
            5:       val = Z_W'(64'sd21354465);
            6:       val = Z_W'(64'sd10680350);
            7:       val = Z_W'(64'sd5340245);
            8:       val = Z_W'(64'sd2670163);
            9:       val = Z_W'(64'sd1335087);
            10:      val = Z_W'(64'sd667544);
            11:      val = Z_W'(64'sd333772);
            12:      val = Z_W'(64'sd166886);
            13:      val = Z_W'(64'sd83443);
            14:      val = Z_W'(64'sd41722);
            15:      val = Z_W'(64'sd20861);
            16:      val = Z_W'(64'sd10430);
            17:      val = Z_W'(64'sd5215);
            18:      val = Z_W'(64'sd2608);
            19:      val = Z_W'(64'sd1304);
            20:      val = Z_W'(64'sd652);
            21:      val = Z_W'(64'sd326);
            22:      val = Z_W'(64'sd163);
            23:      val = Z_W'(64'sd81);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

/* rtl/core/aarm_cordic_cell.sv */
// ----------------------------------------------------------------------------
// aarm_cordic_cell
// One rotation-mode CORDIC micro-rotation with its own pipeline register.
// ----------------------------------------------------------------------------
module aarm_cordic_cell
    import aarm_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  cordic_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output cordic_t out_data
);

    localparam logic signed [Z_W-1:0] ATAN = atan_q31(SHIFT);

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        dx        = in_data.y >>> SHIFT;
        dy        = in_data.x >>> SHIFT;
        data_next = in_data;
        if (!in_data.z[Z_W-1]) begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - ATAN;
        end else begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

/* rtl/core/aarm_matrix.sv */
// ----------------------------------------------------------------------------
// aarm_matrix
// Rounds and clamps sine/cosine, forms the Rodrigues products over two
// multiply stages and drives the saturated matrix entries into the output
// register.
// ----------------------------------------------------------------------------
module aarm_matrix
    import aarm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cordic_t              in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [M_TDATA_W-1:0] out_data
);

    localparam int SH  = INT_FRAC - FRAC_BITS;
    localparam int CW  = FRAC_BITS + 2;
    localparam int TW  = FRAC_BITS + 3;
    localparam int P1W = TW + AXIS_W;
    localparam int P2W = P1W + AXIS_W;
    localparam int SW  = CW + AXIS_W;
    localparam int EW  = P2W + 1;

    localparam logic signed [XY_W-1:0] ONE_XY  = XY_W'(1) <<< FRAC_BITS;
    localparam logic signed [XY_W-1:0] HALF_XY = XY_W'(1) <<< (SH - 1);
    localparam logic signed [TW-1:0]   ONE_T   = TW'(1) <<< FRAC_BITS;
    localparam logic signed [SW-1:0]   HALF_S  = SW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [P2W-1:0]  HALF_P  = P2W'(1) <<< (2 * FRAC_BITS - 1);
    localparam logic signed [EW-1:0]   EMAX    = EW'(65535);
    localparam logic signed [EW-1:0]   EMIN    = EW'(-65536);

    function automatic logic signed [ENTRY_W-1:0] sat(input logic signed [EW-1:0] v);
        logic signed [ENTRY_W-1:0] r;
        if (v > EMAX) begin
            r = ENTRY_W'(EMAX);
        end else if (v < EMIN) begin
            r = ENTRY_W'(EMIN);
        end else begin
            r = ENTRY_W'(v);
        end
        return r;
    endfunction

    function automatic logic signed [CW-1:0] to_q(input logic signed [XY_W-1:0] v,
                                                  input logic flip);
        logic signed [XY_W-1:0] f;
        logic signed [XY_W-1:0] r;
        logic signed [CW-1:0]   q;
        f = flip ? -v : v;
        r = (f + HALF_XY) >>> SH;
        if (r > ONE_XY) begin
            q = CW'(ONE_XY);
        end else if (r < -ONE_XY) begin
            q = CW'(-ONE_XY);
        end else begin
            q = CW'(r);
        end
        return q;
    endfunction

    // stage valid flags and ready chain
    logic va_reg, vb_reg, vc_reg, vd_reg;
    logic rdy_a, rdy_b, rdy_c, rdy_d;

    assign rdy_d     = !vd_reg || out_ready;
    assign rdy_c     = !vc_reg || rdy_d;
    assign rdy_b     = !vb_reg || rdy_c;
    assign rdy_a     = !va_reg || rdy_b;
    assign in_ready  = rdy_a;
    assign out_valid = vd_reg;

    // stage A: sine/cosine in Q.FRAC_BITS, t = 1 - c
    logic signed [CW-1:0]     c_a_reg, s_a_reg, c_a_next, s_a_next;
    logic signed [TW-1:0]     t_a_reg, t_a_next;
    logic signed [AXIS_W-1:0] ux_a_reg, uy_a_reg, uz_a_reg;

    always_comb begin
        c_a_next = to_q(in_data.x, in_data.flip);
        s_a_next = to_q(in_data.y, in_data.flip);
        t_a_next = ONE_T - TW'(c_a_next);
    end

    // stage B: first products
    logic signed [P1W-1:0]    tx_b_reg, ty_b_reg, tz_b_reg;
    logic signed [SW-1:0]     sx_b_reg, sy_b_reg, sz_b_reg;
    logic signed [CW-1:0]     c_b_reg;
    logic signed [AXIS_W-1:0] ux_b_reg, uy_b_reg, uz_b_reg;

    // stage C: second products, rounded sine terms
    logic signed [P2W-1:0] txx_c_reg, tyy_c_reg, tzz_c_reg;
    logic signed [P2W-1:0] txy_c_reg, txz_c_reg, tyz_c_reg;
    logic signed [SW-1:0]  sx_c_reg, sy_c_reg, sz_c_reg;
    logic signed [CW-1:0]  c_c_reg;

    // stage D: rounding of products, sums, saturation
    logic signed [EW-1:0] txx_r, tyy_r, tzz_r, txy_r, txz_r, tyz_r;
    logic signed [EW-1:0] sx_r, sy_r, sz_r, c_r;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    always_comb begin
        txx_r = EW'((txx_c_reg + HALF_P) >>> (2 * FRAC_BITS));
        tyy_r = EW'((tyy_c_reg + HALF_P) >>> (2 * FRAC_BITS));
        tzz_r = EW'((tzz_c_reg + HALF_P) >>> (2 * FRAC_BITS));
        txy_r = EW'((txy_c_reg + HALF_P) >>> (2 * FRAC_BITS));
        txz_r = EW'((txz_c_reg + HALF_P) >>> (2 * FRAC_BITS));
        tyz_r = EW'((tyz_c_reg + HALF_P) >>> (2 * FRAC_BITS));
        sx_r  = EW'(sx_c_reg);
        sy_r  = EW'(sy_c_reg);
        sz_r  = EW'(sz_c_reg);
        c_r   = EW'(c_c_reg);
        m_data_next = '0;
        m_data_next[0*ENTRY_W +: ENTRY_W] = sat(txx_r + c_r);
        m_data_next[1*ENTRY_W +: ENTRY_W] = sat(txy_r - sz_r);
        m_data_next[2*ENTRY_W +: ENTRY_W] = sat(txz_r + sy_r);
        m_data_next[3*ENTRY_W +: ENTRY_W] = sat(txy_r + sz_r);
        m_data_next[4*ENTRY_W +: ENTRY_W] = sat(tyy_r + c_r);
        m_data_next[5*ENTRY_W +: ENTRY_W] = sat(tyz_r - sx_r);
        m_data_next[6*ENTRY_W +: ENTRY_W] = sat(txz_r - sy_r);
        m_data_next[7*ENTRY_W +: ENTRY_W] = sat(tyz_r + sx_r);
        m_data_next[8*ENTRY_W +: ENTRY_W] = sat(tzz_r + c_r);
    end

    assign out_data = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            if (rdy_a) begin
                va_reg <= in_valid;
            end
            if (rdy_b) begin
                vb_reg <= va_reg;
            end
            if (rdy_c) begin
                vc_reg <= vb_reg;
            end
            if (rdy_d) begin
                vd_reg <= vc_reg;
            end
        end

        if (in_valid && rdy_a) begin
            c_a_reg  <= c_a_next;
            s_a_reg  <= s_a_next;
            t_a_reg  <= t_a_next;
            ux_a_reg <= in_data.ux;
            uy_a_reg <= in_data.uy;
            uz_a_reg <= in_data.uz;
        end

        if (va_reg && rdy_b) begin
            tx_b_reg <= P1W'(t_a_reg) * P1W'(ux_a_reg);
            ty_b_reg <= P1W'(t_a_reg) * P1W'(uy_a_reg);
            tz_b_reg <= P1W'(t_a_reg) * P1W'(uz_a_reg);
            sx_b_reg <= SW'(s_a_reg) * SW'(ux_a_reg);
            sy_b_reg <= SW'(s_a_reg) * SW'(uy_a_reg);
            sz_b_reg <= SW'(s_a_reg) * SW'(uz_a_reg);
            c_b_reg  <= c_a_reg;
            ux_b_reg <= ux_a_reg;
            uy_b_reg <= uy_a_reg;
            uz_b_reg <= uz_a_reg;
        end

        if (vb_reg && rdy_c) begin
            txx_c_reg <= P2W'(tx_b_reg) * P2W'(ux_b_reg);
            txy_c_reg <= P2W'(tx_b_reg) * P2W'(uy_b_reg);
            txz_c_reg <= P2W'(tx_b_reg) * P2W'(uz_b_reg);
            tyy_c_reg <= P2W'(ty_b_reg) * P2W'(uy_b_reg);
            tyz_c_reg <= P2W'(ty_b_reg) * P2W'(uz_b_reg);
            tzz_c_reg <= P2W'(tz_b_reg) * P2W'(uz_b_reg);
            sx_c_reg  <= (sx_b_reg + HALF_S) >>> FRAC_BITS;
            sy_c_reg  <= (sy_b_reg + HALF_S) >>> FRAC_BITS;
            sz_c_reg  <= (sz_b_reg + HALF_S) >>> FRAC_BITS;
            c_c_reg   <= c_b_reg;
        end

        if (vc_reg && rdy_d) begin
            m_data_reg <= m_data_next;
        end
    end

    // cosine and sine stay within +-1.0 after clamping
    assert property (@(posedge aclk) disable iff (!aresetn)
        va_reg |-> (CW'(c_a_reg) <= CW'(ONE_XY)) && (c_a_reg >= -CW'(ONE_XY)))
        else $error("cosine out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        va_reg |-> (s_a_reg <= CW'(ONE_XY)) && (s_a_reg >= -CW'(ONE_XY)))
        else $error("sine out of range");

    // a word only appears in stage B if stage A held one
    assert property (@(posedge aclk) disable iff (!aresetn)
        !vb_reg ##1 vb_reg |-> $past(va_reg))
        else $error("stage B word without source");

    // a stalled output stage never takes a new word
    assert property (@(posedge aclk) disable iff (!aresetn)
        vd_reg && !out_ready |=> vd_reg && $stable(m_data_reg))
        else $error("output word lost under stall");

endmodule

/* rtl/core/axis_angle_rotation_matrix_core.sv */
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_core
// Pipeline: min(CORDIC_STAGES, 24) CORDIC cells from s_ word to m_ word, each with its
// own register, then four registered stages for rounding, products and sums.
// Throughput: one matrix per cycle while m_tready is high; every stage is a registered slot.
// Reset: aresetn clears only the stage valid flags; no other state.
// Rodrigues rotation matrix from a binary angle and a Q.FRAC_BITS axis.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_core
    import aarm_pkg::*;
#(
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // angle, axis_x, axis_y, axis_z
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // m00 m01 m02 m10 m11 m12 m20 m21 m22, pad
);

    localparam int NSTAGES = (CORDIC_STAGES < ATAN_TAB_LEN) ? CORDIC_STAGES : ATAN_TAB_LEN;

    logic signed [ANGLE_W-1:0] angle;
    logic signed [Z_W-1:0]     z_raw;
    cordic_t                   start_word;

    cordic_t chain_data  [NSTAGES+1];
    logic    chain_valid [NSTAGES+1];
    logic    chain_ready [NSTAGES+1];

    assign angle = s_tdata[0 +: ANGLE_W];
    assign z_raw = {angle[ANGLE_W-1], angle, 16'b0};

    // fold angles outside [-pi/2, pi/2) by pi; the sign of the result flips at the end
    always_comb begin
        start_word      = '0;
        start_word.x    = CORDIC_GAIN;
        start_word.y    = '0;
        start_word.ux   = s_tdata[16 +: AXIS_W];
        start_word.uy   = s_tdata[32 +: AXIS_W];
        start_word.uz   = s_tdata[48 +: AXIS_W];
        start_word.flip = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
        if (!start_word.flip) begin
            start_word.z = z_raw;
        end else if (!angle[ANGLE_W-1]) begin
            start_word.z = z_raw - HALF_TURN;
        end else begin
            start_word.z = z_raw + HALF_TURN;
        end
    end

    assign chain_data[0]  = start_word;
    assign chain_valid[0] = s_tvalid;
    assign s_tready       = chain_ready[0];

    for (genvar i = 0; i < NSTAGES; i++) begin : g_cell
        aarm_cordic_cell #(
            .SHIFT(i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    aarm_matrix #(
        .FRAC_BITS(FRAC_BITS)
    ) u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chain_valid[NSTAGES]),
        .in_ready  (chain_ready[NSTAGES]),
        .in_data   (chain_data[NSTAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
